// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: src/sled_pkg.sv
package sled_pkg;

  localparam int MAX_ESCAPE_DIGITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF       = 4;
  localparam int MAX_BYTES             = 4;

  localparam logic [1:0] MODE_REGULAR = 2'd0;
  localparam logic [1:0] MODE_HEX     = 2'd1;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_HI   = 8'h55;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BSLASH = 3'd1,
    PH_XHEX   = 3'd2,
    PH_UHEX   = 3'd3,
    PH_OCT    = 3'd4
  } sled_phase_t;

  // Bytes produced by one input character.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                n;
  } sled_emit_t;

  // One queue entry: the results of one accepted character.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                last_idx;
    logic                      has_byte;
    logic                      eos;
  } sled_cmd_t;

  function automatic sled_emit_t emit_add(sled_emit_t e, logic [7:0] v);
    sled_emit_t r;
    r = e;
    if (e.n < 3'(MAX_BYTES)) begin
      r.bytes[e.n[1:0]] = v;
      r.n = e.n + 3'd1;
    end
    return r;
  endfunction

  function automatic sled_emit_t emit_utf8(sled_emit_t e, logic [31:0] cp);
    sled_emit_t r;
    r = e;
    if (cp < 32'h80) begin
      r = emit_add(r, cp[7:0]);
    end else if (cp < 32'h800) begin
      r = emit_add(r, 8'hC0 | {3'b000, cp[10:6]});
      r = emit_add(r, 8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 32'h10000) begin
      r = emit_add(r, 8'hE0 | {4'b0000, cp[15:12]});
      r = emit_add(r, 8'h80 | {2'b00, cp[11:6]});
      r = emit_add(r, 8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 32'h110000) begin
      r = emit_add(r, 8'hF0 | {5'b00000, cp[20:18]});
      r = emit_add(r, 8'h80 | {2'b00, cp[17:12]});
      r = emit_add(r, 8'h80 | {2'b00, cp[11:6]});
      r = emit_add(r, 8'h80 | {2'b00, cp[5:0]});
    end
    return r;
  endfunction

  // Emits whatever a pending escape stands for.
  function automatic sled_emit_t emit_finish(sled_emit_t e, sled_phase_t ph,
                                             logic [31:0] v);
    sled_emit_t r;
    r = e;
    case (ph)
      PH_BSLASH: r = emit_add(r, 8'h00);
      PH_XHEX:   r = emit_add(r, v[7:0]);
      PH_UHEX:   r = emit_utf8(r, v);
      PH_OCT:    r = emit_add(r, v[7:0]);
      default:   r = e;
    endcase
    return r;
  endfunction

  // Returns a valid flag above the nibble value.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [7:0] ctrl_map(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h66:   r = 8'd12;
      8'h6E:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// File: src/sled_if.sv
interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_string;

  modport source (output valid, in_char, end_of_string, input ready);
  modport sink   (input valid, in_char, end_of_string, output ready);
endinterface

interface sled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_string;

  modport source (output valid, out_byte, has_byte, last_of_string, input ready);
  modport sink   (input valid, out_byte, has_byte, last_of_string, output ready);
endinterface

// File: src/sled_front.sv
module sled_front #(
  parameter int MAX_ESCAPE_DIGITS = sled_pkg::MAX_ESCAPE_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  sled_in_if.sink             chars,
  input  logic                push_ready,
  output logic                push_valid,
  output sled_pkg::sled_cmd_t push_cmd
);

  localparam int VW = 4 * MAX_ESCAPE_DIGITS;

  logic [1:0]            mode;
  sled_pkg::sled_phase_t phase, phase_next;
  logic [3:0]            taken, taken_next;
  logic [3:0]            wanted, wanted_next;
  logic                  still_valid, still_valid_next;
  logic [VW-1:0]         value, value_next;
  logic [7:0]            hex_byte, hex_byte_next;
  logic                  hex_pend, hex_pend_next;
  sled_pkg::sled_emit_t  em;
  logic                  fire;
  logic [7:0]            c;
  logic [4:0]            hv;

  assign c           = chars.in_char;
  assign hv          = sled_pkg::hex_val(c);
  assign chars.ready = push_ready;
  assign fire        = chars.valid && push_ready;

  always_comb begin
    phase_next       = phase;
    taken_next       = taken;
    wanted_next      = wanted;
    still_valid_next = still_valid;
    value_next       = value;
    hex_byte_next    = hex_byte;
    hex_pend_next    = hex_pend;
    em               = '0;

    if (mode == sled_pkg::MODE_REGULAR) begin
      case (phase)
        sled_pkg::PH_BSLASH: begin
          phase_next = sled_pkg::PH_IDLE;
          taken_next = 4'd0;
          wanted_next = 4'd0;
          still_valid_next = 1'b1;
          value_next = '0;
          if (c == sled_pkg::CH_X) begin
            phase_next = sled_pkg::PH_XHEX;
            wanted_next = 4'd2;
          end else if (c == sled_pkg::CH_U_LO) begin
            phase_next = sled_pkg::PH_UHEX;
            wanted_next = 4'd4;
          end else if (c == sled_pkg::CH_U_HI) begin
            phase_next = sled_pkg::PH_UHEX;
            wanted_next = 4'(MAX_ESCAPE_DIGITS);
          end else if (c >= sled_pkg::CH_ZERO && c <= sled_pkg::CH_SEVEN) begin
            phase_next = sled_pkg::PH_OCT;
            value_next = VW'(c[2:0]);
            taken_next = 4'd1;
          end else begin
            em = sled_pkg::emit_add(em, sled_pkg::ctrl_map(c));
          end
        end
        sled_pkg::PH_XHEX, sled_pkg::PH_UHEX: begin
          if (still_valid && hv[4]) value_next = {value[VW-5:0], hv[3:0]};
          else still_valid_next = 1'b0;
          taken_next = taken + 4'd1;
          if (taken_next >= wanted) begin
            em = sled_pkg::emit_finish(em, phase, 32'(value_next));
            phase_next = sled_pkg::PH_IDLE;
            taken_next = 4'd0;
            wanted_next = 4'd0;
            still_valid_next = 1'b1;
            value_next = '0;
          end
        end
        sled_pkg::PH_OCT: begin
          if (c >= sled_pkg::CH_ZERO && c <= sled_pkg::CH_SEVEN) begin
            value_next = '0;
            value_next[10:0] = {value[7:0], c[2:0]};
            taken_next = taken + 4'd1;
            if (taken_next >= 4'd3) begin
              em = sled_pkg::emit_finish(em, phase, 32'(value_next));
              phase_next = sled_pkg::PH_IDLE;
              taken_next = 4'd0;
              value_next = '0;
            end
          end else begin
            em = sled_pkg::emit_finish(em, phase, 32'(value));
            phase_next = sled_pkg::PH_IDLE;
            taken_next = 4'd0;
            value_next = '0;
            if (c == sled_pkg::CH_BSLASH) phase_next = sled_pkg::PH_BSLASH;
            else em = sled_pkg::emit_add(em, c);
          end
        end
        default: begin
          if (c == sled_pkg::CH_BSLASH) phase_next = sled_pkg::PH_BSLASH;
          else em = sled_pkg::emit_add(em, c);
        end
      endcase
    end else if (mode == sled_pkg::MODE_HEX) begin
      if (hv[4]) begin
        if (hex_pend) begin
          em = sled_pkg::emit_add(em, {hex_byte[3:0], hv[3:0]});
          hex_byte_next = 8'd0;
          hex_pend_next = 1'b0;
        end else begin
          hex_byte_next = {hex_byte[3:0], hv[3:0]};
          hex_pend_next = 1'b1;
        end
      end
    end else begin
      em = sled_pkg::emit_add(em, c);
    end

    if (chars.end_of_string) begin
      if (mode == sled_pkg::MODE_REGULAR)
        em = sled_pkg::emit_finish(em, phase_next, 32'(value_next));
      phase_next       = sled_pkg::PH_IDLE;
      taken_next       = 4'd0;
      wanted_next      = 4'd0;
      still_valid_next = 1'b1;
      value_next       = '0;
      hex_byte_next    = 8'd0;
      hex_pend_next    = 1'b0;
    end
  end

  always_comb begin
    push_valid        = fire && (em.n != 3'd0 || chars.end_of_string);
    push_cmd.bytes    = em.bytes;
    push_cmd.has_byte = em.n != 3'd0;
    push_cmd.last_idx = (em.n == 3'd0) ? 2'd0 : 2'(em.n - 3'd1);
    push_cmd.eos      = chars.end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sled_pkg::MODE_REGULAR;
      phase       <= sled_pkg::PH_IDLE;
      taken       <= 4'd0;
      wanted      <= 4'd0;
      still_valid <= 1'b1;
      value       <= '0;
      hex_byte    <= 8'd0;
      hex_pend    <= 1'b0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (fire) begin
        phase       <= phase_next;
        taken       <= taken_next;
        wanted      <= wanted_next;
        still_valid <= still_valid_next;
        value       <= value_next;
        hex_byte    <= hex_byte_next;
        hex_pend    <= hex_pend_next;
      end
    end
  end

endmodule

// File: src/sled_queue.sv
`include "assert_macros.svh"

module sled_queue #(
  parameter int DEPTH = sled_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  sled_pkg::sled_cmd_t push_cmd,
  output logic                head_valid,
  output sled_pkg::sled_cmd_t head_cmd,
  input  logic                pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sled_pkg::sled_cmd_t mem [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;
  logic                push;

  assign push_ready = count != CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = mem[rd_ptr];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_IMPLIES(a_pop_nonempty, pop, count != '0, "pop from an empty queue")
  `ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + 1'b1, "count did not grow")

endmodule

// File: src/sled_back.sv
`include "assert_macros.svh"

module sled_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  sled_pkg::sled_cmd_t head_cmd,
  output logic                pop,
  sled_out_if.source          bytes_out
);

  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;
  logic       load;

  assign load = head_valid && (!out_valid || bytes_out.ready);
  assign pop  = load && idx == head_cmd.last_idx;

  assign bytes_out.valid          = out_valid;
  assign bytes_out.out_byte       = out_byte;
  assign bytes_out.has_byte       = has_byte;
  assign bytes_out.last_of_string = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= pop ? 2'd0 : idx + 2'd1;
      end else if (bytes_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head_cmd.bytes[idx];
      has_byte <= head_cmd.has_byte;
      last     <= head_cmd.eos && idx == head_cmd.last_idx;
    end
  end

  `ASSERT_IMPLIES(a_idx_in_range, head_valid, idx <= head_cmd.last_idx, "byte index past entry")
  `ASSERT_IMPLIES(a_empty_is_last, out_valid && !has_byte, last, "empty beat not last")

endmodule

// File: src/string_literal_escape_decoder.sv
// Channel    Direction  Beat contents
// char_chan  in         in_char, end_of_string
// byte_chan  out        out_byte, has_byte, last_of_string
// cfg        in         string_mode via cfg_we and cfg_wdata
//
// A character producing several bytes is sent out one byte at a time through the
// single-byte output register.
// A four-entry queue between decoder and output lets input continue meanwhile.
// Reset is synchronous and returns the decoder to idle in regular mode.
// Input stalls only while the queue is full; output stalls hold the register.
module string_literal_escape_decoder #(
  parameter int MAX_ESCAPE_DIGITS = sled_pkg::MAX_ESCAPE_DIGITS_DEF,
  parameter int QUEUE_DEPTH       = sled_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  sled_in_if.sink     char_chan,
  sled_out_if.source  byte_chan
);

  logic                push_valid;
  logic                push_ready;
  sled_pkg::sled_cmd_t push_cmd;
  logic                head_valid;
  sled_pkg::sled_cmd_t head_cmd;
  logic                pop;

  sled_front #(.MAX_ESCAPE_DIGITS(MAX_ESCAPE_DIGITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .chars      (char_chan),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  sled_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  sled_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .bytes_out  (byte_chan)
  );

endmodule
